// File: design/vntu_pkg.sv
// vntu_pkg: shared widths, constants and stage structs for the vertex
// normal/tangent unpack unit; used by every module under design/
`default_nettype none

package vntu_pkg;

   // number of normalized tangent lanes (x, y, z)
   localparam int LANES       = 3;
   // squared byte magnitude, sum of four squares
   localparam int SQ_W        = 15;
   localparam int SUM_W       = 17;
   // restoring divide: quotient bits and partial remainder
   localparam int QUO_W       = 31;
   localparam int DREM_W      = 16;
   // restoring square root: result bits, radicand and partial remainder
   localparam int ROOT_W      = 16;
   localparam int RAD_W       = 2 * ROOT_W;
   localparam int SREM_W      = 17;
   // output component width (signed Q2.14)
   localparam int COMP_W      = 16;
   localparam int WORD_W      = 32;
   // stages between the front end and the output register
   localparam int SIDE_DELAY  = QUO_W + ROOT_W;

   // normal divide by 511: 2*x + 511 over 1022, x = 32 * magnitude
   localparam logic [15:0] NORM_OFFSET = 16'd511;
   localparam logic [10:0] NORM_DIV2   = 11'd1022;
   // tangent w over 127 rounds up once the magnitude reaches half of 127
   localparam logic [7:0]  W_ROUND_MIN = 8'd64;

   // side information that travels next to the normalize lanes
   typedef struct packed {
      logic                          use_tan;
      logic                          skipped;
      logic [LANES-1:0]              tan_neg;
      logic [LANES-1:0][COMP_W-1:0]  norm_comp;
      logic [COMP_W-1:0]             comp_w;
   } vntu_side_type;

   // front end result handed to the lanes
   typedef struct packed {
      logic [LANES-1:0][SQ_W-1:0]    sq;
      logic [SUM_W-1:0]              sum;
      vntu_side_type                 side;
   } vntu_front_type;

endpackage

`default_nettype wire

// File: design/vntu_front.sv
// vntu_front: two register stages that unpack the attribute word, square the
// tangent bytes and finish the normal and tangent w divides; uses vntu_pkg
`default_nettype none

module vntu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic                     in_func,
   input  logic [31:0]              in_word,
   output logic                     out_valid,
   output vntu_pkg::vntu_front_type out_data
);
   import vntu_pkg::*;

   // first stage registers
   logic                         s1_valid_ff;
   logic                         s1_func_ff;
   logic [LANES-1:0]             s1_nneg_ff;
   logic [LANES-1:0][9:0]        s1_nmag_ff;
   logic [3:0]                   s1_tneg_ff;
   logic [3:0][SQ_W-1:0]         s1_sq_ff;
   logic [7:0]                   s1_tmag3_ff;

   logic [LANES-1:0]             nneg_in;
   logic [LANES-1:0][9:0]        nmag_in;
   logic [3:0]                   tneg_in;
   logic [3:0][SQ_W-1:0]         sq_in;
   logic [7:0]                   tmag3_in;

   // second stage registers
   logic                         s2_valid_ff;
   vntu_front_type               s2_data_ff;
   vntu_front_type               s2_data_in;

   // unpack fields, take magnitudes, square the tangent bytes
   always_comb begin
      logic [9:0]  field;
      logic [7:0]  byte_v;
      logic [7:0]  tmag;
      logic [15:0] prod;
      tmag3_in = '0;
      for (int i = 0; i < LANES; i++) begin
         field      = in_word[10*i +: 10];
         nneg_in[i] = field[9];
         nmag_in[i] = field[9] ? (~field + 10'd1) : field;
      end
      for (int i = 0; i < 4; i++) begin
         byte_v     = in_word[8*i +: 8];
         tneg_in[i] = byte_v[7];
         tmag       = byte_v[7] ? (~byte_v + 8'd1) : byte_v;
         prod       = {8'b0, tmag} * {8'b0, tmag};
         sq_in[i]   = prod[SQ_W-1:0];
         if (i == 3) begin
            tmag3_in = tmag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff  <= in_func;
         s1_nneg_ff  <= nneg_in;
         s1_nmag_ff  <= nmag_in;
         s1_tneg_ff  <= tneg_in;
         s1_sq_ff    <= sq_in;
         s1_tmag3_ff <= tmag3_in;
      end
   end

   // sum of squares, normal components over 511, tangent w over 127
   always_comb begin
      logic [14:0] x32;
      logic [15:0] y;
      logic [5:0]  q_est;
      logic [10:0] r;
      logic [14:0] nm;
      logic [14:0] wmag;
      logic        skip;
      s2_data_in.sum = SUM_W'(s1_sq_ff[0]) + SUM_W'(s1_sq_ff[1])
                     + SUM_W'(s1_sq_ff[2]) + SUM_W'(s1_sq_ff[3]);
      for (int i = 0; i < LANES; i++) begin
         // 16384/511 = 32 + 32/511: quotient of the small part from y/1024
         // plus one correction
         x32   = {s1_nmag_ff[i], 5'b0};
         y     = {s1_nmag_ff[i], 6'b0} + NORM_OFFSET;
         q_est = y[15:10];
         r     = {1'b0, y[9:0]} + {4'b0, q_est, 1'b0};
         nm    = x32 + 15'(q_est) + 15'(r >= NORM_DIV2);
         s2_data_in.side.norm_comp[i] = s1_func_ff ? '0 :
            (s1_nneg_ff[i] ? -{1'b0, nm} : {1'b0, nm});
         s2_data_in.sq[i] = s1_sq_ff[i];
      end
      // 16384/127 = 129 + 1/127
      skip = s1_func_ff & (s1_tmag3_ff == 8'd0);
      wmag = {s1_tmag3_ff, 7'b0} + 15'(s1_tmag3_ff) + 15'(s1_tmag3_ff >= W_ROUND_MIN);
      s2_data_in.side.comp_w = (s1_func_ff & !skip) ?
         (s1_tneg_ff[3] ? -{1'b0, wmag} : {1'b0, wmag}) : '0;
      s2_data_in.side.use_tan = s1_func_ff & !skip;
      s2_data_in.side.skipped = skip;
      s2_data_in.side.tan_neg = s1_tneg_ff[LANES-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

// File: design/vntu_div_pipe.sv
// vntu_div_pipe: pipelined restoring divider, one quotient bit per stage,
// computes floor(sq * 2^30 / sum); uses vntu_pkg
`default_nettype none

module vntu_div_pipe (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [vntu_pkg::SQ_W-1:0]     in_sq,
   input  logic [vntu_pkg::SUM_W-1:0]    in_sum,
   output logic [vntu_pkg::QUO_W-1:0]    out_quo
);
   import vntu_pkg::*;

   logic [DREM_W-1:0] rem_ff [0:QUO_W-2];
   logic [SUM_W-1:0]  sum_ff [0:QUO_W-2];
   logic [QUO_W-1:0]  quo_ff [0:QUO_W-1];

   // one stage per quotient bit, most significant first
   for (genvar g = 0; g < QUO_W; g++) begin : g_step
      logic [DREM_W-1:0] rem_src;
      logic              bit_src;
      logic [SUM_W-1:0]  sum_src;
      logic [QUO_W-1:0]  quo_src;
      logic [SUM_W-1:0]  shifted;
      logic              ge;
      logic [QUO_W-1:0]  quo_in;

      // first stage starts from the upper bits of the dividend
      if (g == 0) begin : g_first
         assign rem_src = {2'b0, in_sq[SQ_W-1:1]};
         assign bit_src = in_sq[0];
         assign sum_src = in_sum;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign bit_src = 1'b0;
         assign sum_src = sum_ff[g-1];
         assign quo_src = quo_ff[g-1];
      end

      assign shifted = {rem_src, bit_src};
      assign ge      = (shifted >= sum_src);

      always_comb begin
         quo_in = quo_src;
         quo_in[QUO_W-1-g] = ge;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quo_ff[g] <= quo_in;
         end
      end

      // partial remainder stays below the divisor
      if (g < QUO_W - 1) begin : g_keep
         logic [SUM_W-1:0]  diff;
         logic [DREM_W-1:0] rem_in;
         assign diff   = shifted - sum_src;
         assign rem_in = ge ? diff[DREM_W-1:0] : shifted[DREM_W-1:0];
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[g] <= rem_in;
               sum_ff[g] <= sum_src;
            end
         end
      end
   end

   assign out_quo = quo_ff[QUO_W-1];

endmodule

`default_nettype wire

// File: design/vntu_sqrt_pipe.sv
// vntu_sqrt_pipe: pipelined restoring integer square root, one root bit per
// stage; uses vntu_pkg
`default_nettype none

module vntu_sqrt_pipe (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [vntu_pkg::QUO_W-1:0]    in_quo,
   output logic [vntu_pkg::ROOT_W-1:0]   out_root
);
   import vntu_pkg::*;

   logic [SREM_W-1:0] rem_ff  [0:ROOT_W-2];
   logic [RAD_W-1:0]  rad_ff  [0:ROOT_W-2];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W-1];

   // one stage per root bit, two radicand bits consumed per stage
   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      localparam int P = ROOT_W - 1 - g;
      logic [SREM_W-1:0] rem_src;
      logic [RAD_W-1:0]  rad_src;
      logic [ROOT_W-1:0] root_src;
      logic [SREM_W+1:0] rem_sh;
      logic [SREM_W+1:0] trial;
      logic              ge;
      logic [ROOT_W-1:0] root_in;

      if (g == 0) begin : g_first
         assign rem_src  = '0;
         assign rad_src  = {{(RAD_W-QUO_W){1'b0}}, in_quo};
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign rad_src  = rad_ff[g-1];
         assign root_src = root_ff[g-1];
      end

      assign rem_sh  = {rem_src, rad_src[2*P+1:2*P]};
      assign trial   = {{(SREM_W+2-ROOT_W-2){1'b0}}, root_src, 2'b01};
      assign ge      = (rem_sh >= trial);
      assign root_in = {root_src[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (advance) begin
            root_ff[g] <= root_in;
         end
      end

      // remainder is at most twice the partial root
      if (g < ROOT_W - 1) begin : g_keep
         logic [SREM_W+1:0] diff;
         logic [SREM_W-1:0] rem_in;
         assign diff   = rem_sh - trial;
         assign rem_in = ge ? diff[SREM_W-1:0] : rem_sh[SREM_W-1:0];
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[g] <= rem_in;
               rad_ff[g] <= rad_src;
            end
         end
      end
   end

   assign out_root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire

// File: design/vertex_normal_tangent_unpack_unit.sv
// vertex_normal_tangent_unpack_unit: decodes 10:10:10:2 normals and signed
// byte tangents to signed Q2.14; uses vntu_pkg and the front, divide and root pipes
// path: a result passes through 2 front stages, 31 divide stages,
//   16 square root stages and the output register
// throughput: one transaction per cycle, held by the one-bit-per-stage divide
//   and square root pipes; a stall freezes the whole pipe
// reset: clears the valid bits only; no clearing pass, ready the cycle after
`default_nettype none

module vertex_normal_tangent_unpack_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [31:0]        req_attribute_word,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_comp_x,
   output logic signed [15:0] rsp_comp_y,
   output logic signed [15:0] rsp_comp_z,
   output logic signed [15:0] rsp_comp_w,
   output logic               rsp_skipped
);
   import vntu_pkg::*;

   logic                           advance;
   logic                           front_valid;
   vntu_front_type                 front_data;
   logic [LANES-1:0][QUO_W-1:0]    quo;
   logic [LANES-1:0][ROOT_W-1:0]   root;

   logic [SIDE_DELAY-1:0]          side_valid_ff;
   vntu_side_type                  side_ff [0:SIDE_DELAY-1];

   logic                           rsp_valid_ff;
   logic [LANES-1:0][COMP_W-1:0]   comp_ff;
   logic [COMP_W-1:0]              comp_w_ff;
   logic                           skipped_ff;
   logic [LANES-1:0][COMP_W-1:0]   comp_in;

   // the pipe moves whenever the output register is empty or being taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   vntu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_func   (req_func),
      .in_word   (req_attribute_word),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // tangent normalize lanes: isqrt(sq * 2^30 / sum)
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      vntu_div_pipe u_div (
         .clock   (clock),
         .advance (advance),
         .in_sq   (front_data.sq[l]),
         .in_sum  (front_data.sum),
         .out_quo (quo[l])
      );

      vntu_sqrt_pipe u_sqrt (
         .clock    (clock),
         .advance  (advance),
         .in_quo   (quo[l]),
         .out_root (root[l])
      );
   end

   // side information and valid bits keep pace with the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         side_valid_ff <= '0;
      end else if (advance) begin
         side_valid_ff <= {side_valid_ff[SIDE_DELAY-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= front_data.side;
         for (int i = 1; i < SIDE_DELAY; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // add one to the root and halve to round to nearest, apply sign; normals pass through
   always_comb begin
      logic [ROOT_W:0]   rounded;
      logic [COMP_W-1:0] mag;
      for (int l = 0; l < LANES; l++) begin
         rounded = {1'b0, root[l]} + {{ROOT_W{1'b0}}, 1'b1};
         mag     = rounded[ROOT_W:1];
         if (side_ff[SIDE_DELAY-1].use_tan) begin
            comp_in[l] = side_ff[SIDE_DELAY-1].tan_neg[l] ? -mag : mag;
         end else begin
            comp_in[l] = side_ff[SIDE_DELAY-1].norm_comp[l];
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= side_valid_ff[SIDE_DELAY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         comp_ff    <= comp_in;
         comp_w_ff  <= side_ff[SIDE_DELAY-1].comp_w;
         skipped_ff <= side_ff[SIDE_DELAY-1].skipped;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_comp_x  = comp_ff[0];
   assign rsp_comp_y  = comp_ff[1];
   assign rsp_comp_z  = comp_ff[2];
   assign rsp_comp_w  = comp_w_ff;
   assign rsp_skipped = skipped_ff;

endmodule

`default_nettype wire

// File: sim/vertex_normal_tangent_unpack_unit_test.sv
// vertex_normal_tangent_unpack_unit_test: self-checking bench for the vertex
// normal/tangent unpack unit; predicts each decoded vertex and checks it in order
// depends on vntu_pkg and vertex_normal_tangent_unpack_unit
`timescale 1ns / 100ps

module vertex_normal_tangent_unpack_unit_test;
   import vntu_pkg::*;

   localparam bit FUNC_NORMAL  = 1'b0;
   localparam bit FUNC_TANGENT = 1'b1;
   localparam int IDLE_LIMIT   = 2000;
   localparam int HOLD_CYCLES  = 150;
   localparam int TAIL_CYCLES  = 60;

   // one decoded vertex as seen on the response channel
   typedef struct packed {
      logic signed [COMP_W-1:0] x;
      logic signed [COMP_W-1:0] y;
      logic signed [COMP_W-1:0] z;
      logic signed [COMP_W-1:0] w;
      logic                     skipped;
   } vertex_result_type;

   // predicts decoded vertices and checks responses in arrival order
   class unpack_scoreboard;
      vertex_result_type expected_vertices[$];
      int unsigned       mismatch_count;

      // signed 10-bit field over 511, rounded to Q2.14
      function logic signed [COMP_W-1:0] snorm10_q14(logic [9:0] field);
         int          value;
         int unsigned mag;
         int unsigned quot;
         value = int'($signed(field));
         mag   = (value < 0) ? -value : value;
         quot  = (mag * 32768 + 511) / 1022;
         return COMP_W'((value < 0) ? -quot : quot);
      endfunction

      // t / sqrt(sum_sq) in Q2.14: largest k with (2k-1)^2 * sum_sq <= t^2 * 2^30
      function logic signed [COMP_W-1:0] unit_component(int t, int unsigned sum_sq);
         longint unsigned mag;
         longint unsigned bound;
         longint unsigned odd;
         int unsigned     lo;
         int unsigned     hi;
         int unsigned     mid;
         mag   = 64'((t < 0) ? -t : t);
         bound = (mag * mag) << 30;
         lo    = 0;
         hi    = 16384;
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 64'(2 * mid - 1);
            if (odd * odd * sum_sq <= bound) lo = mid;
            else hi = mid - 1;
         end
         return COMP_W'((t < 0) ? -lo : lo);
      endfunction

      function vertex_result_type decode_attribute(bit func, logic [WORD_W-1:0] word);
         vertex_result_type r;
         int                t[4];
         int unsigned       sum_sq;
         int unsigned       w_mag;
         r = '0;
         if (func == FUNC_NORMAL) begin
            r.x = snorm10_q14(word[9:0]);
            r.y = snorm10_q14(word[19:10]);
            r.z = snorm10_q14(word[29:20]);
         end else begin
            sum_sq = 0;
            for (int i = 0; i < 4; i++) begin
               t[i]   = int'($signed(word[8*i +: 8]));
               sum_sq += t[i] * t[i];
            end
            // zero w byte: whole tangent dropped
            if (t[3] == 0) begin
               r.skipped = 1'b1;
            end else begin
               r.x   = unit_component(t[0], sum_sq);
               r.y   = unit_component(t[1], sum_sq);
               r.z   = unit_component(t[2], sum_sq);
               w_mag = (t[3] < 0) ? -t[3] : t[3];
               w_mag = (w_mag * 32768 + 127) / 254;
               r.w   = COMP_W'((t[3] < 0) ? -w_mag : w_mag);
            end
         end
         return r;
      endfunction

      function void note_vertex(bit func, logic [WORD_W-1:0] word);
         expected_vertices.push_back(decode_attribute(func, word));
      endfunction

      function void compare_field(string name, logic [COMP_W-1:0] want,
                                  logic [COMP_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(want), $signed(got));
            mismatch_count++;
         end
      endfunction

      function void check_result(vertex_result_type got);
         vertex_result_type want;
         if (expected_vertices.size() == 0) begin
            $display("%0t: response with no transaction pending, actual %h", $time, got);
            mismatch_count++;
            return;
         end
         want = expected_vertices.pop_front();
         compare_field("comp_x", want.x, got.x);
         compare_field("comp_y", want.y, got.y);
         compare_field("comp_z", want.z, got.z);
         compare_field("comp_w", want.w, got.w);
         compare_field("skipped", COMP_W'(want.skipped), COMP_W'(got.skipped));
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_func;
   logic [WORD_W-1:0]  req_attribute_word;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [15:0] rsp_comp_x;
   logic signed [15:0] rsp_comp_y;
   logic signed [15:0] rsp_comp_z;
   logic signed [15:0] rsp_comp_w;
   logic               rsp_skipped;

   unpack_scoreboard scoreboard;
   int               send_idle_pct;
   int               recv_idle_pct;
   bit               hold_request;
   bit               hold_taken;
   int               hold_left;
   int               quiet_cycles;

   vertex_normal_tangent_unpack_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_func           (req_func),
      .req_attribute_word (req_attribute_word),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_comp_x         (rsp_comp_x),
      .rsp_comp_y         (rsp_comp_y),
      .rsp_comp_z         (rsp_comp_z),
      .rsp_comp_w         (rsp_comp_w),
      .rsp_skipped        (rsp_skipped)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // offer one transaction, with random idle cycles ahead of it
   task automatic push_vertex(input bit func, input logic [WORD_W-1:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid          = 1'b0;
         req_func           = 1'($urandom);
         req_attribute_word = $urandom;
         @(negedge clock);
      end
      req_valid          = 1'b1;
      req_func           = func;
      req_attribute_word = word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scoreboard.note_vertex(func, word);
   endtask

   // sender goes quiet until every response is back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   // random vertices: mixed normals and tangents, some dropped or tiny tangents
   task automatic run_random(input int count);
      bit                func;
      logic [WORD_W-1:0] word;
      for (int n = 0; n < count; n++) begin
         func = 1'($urandom_range(1));
         word = $urandom;
         if ($urandom_range(7) == 0) word = word & 32'h0303_0303;
         if (func == FUNC_TANGENT && $urandom_range(9) == 0) word[31:24] = 8'h00;
         push_vertex(func, word);
      end
   endtask

   // response side stall, with one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         scoreboard.check_result({rsp_comp_x, rsp_comp_y, rsp_comp_z, rsp_comp_w,
                                  rsp_skipped});
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      scoreboard         = new();
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_func           = FUNC_NORMAL;
      req_attribute_word = '0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      hold_request       = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // normals: zero, all -1, full positive, full negative, mixed, top bits set
      push_vertex(FUNC_NORMAL, 32'h0000_0000);
      push_vertex(FUNC_NORMAL, 32'h3FFF_FFFF);
      push_vertex(FUNC_NORMAL, 32'h1FF7_FDFF);
      push_vertex(FUNC_NORMAL, 32'h2008_0200);
      push_vertex(FUNC_NORMAL, 32'h0008_01FF);
      push_vertex(FUNC_NORMAL, 32'hC000_0000);
      push_vertex(FUNC_NORMAL, 32'hFFFF_FFFF);
      push_vertex(FUNC_NORMAL, 32'h0010_0401);
      // tangents with a zero w byte
      push_vertex(FUNC_TANGENT, 32'h0000_0000);
      push_vertex(FUNC_TANGENT, 32'h0080_7F01);
      push_vertex(FUNC_TANGENT, 32'h00FF_FFFF);
      // tangents at the byte extremes
      push_vertex(FUNC_TANGENT, 32'hFFFF_FFFF);
      push_vertex(FUNC_TANGENT, 32'h8080_8080);
      push_vertex(FUNC_TANGENT, 32'h7F7F_7F7F);
      push_vertex(FUNC_TANGENT, 32'h7F00_0000);
      push_vertex(FUNC_TANGENT, 32'h8100_0000);
      push_vertex(FUNC_TANGENT, 32'h8000_0000);
      push_vertex(FUNC_TANGENT, 32'h0100_0000);
      push_vertex(FUNC_TANGENT, 32'hFF00_0000);
      // one large lane against a tiny w, then one mixed tangent
      push_vertex(FUNC_TANGENT, 32'h017F_0000);
      push_vertex(FUNC_TANGENT, 32'h0100_007F);
      push_vertex(FUNC_TANGENT, 32'h0100_8000);
      push_vertex(FUNC_TANGENT, 32'hFF01_80FF);
      push_vertex(FUNC_TANGENT, 32'h4020_E0C0);
      wait_for_results();

      // busy sender, slow receiver
      send_idle_pct = 37;
      recv_idle_pct = 55;
      run_random(150);
      wait_for_results();

      // slow sender, busy receiver
      send_idle_pct = 55;
      recv_idle_pct = 37;
      run_random(150);
      wait_for_results();

      // back to back, with one long response hold-off to fill the pipe
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      run_random(150);
      wait_for_results();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
